@@ hdl/hlc_pkg.sv @@
`timescale 1ns / 1ps
package hlc_pkg;

  localparam int unsigned ID_W    = 64;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned USAGE_W = 8;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [2:0] {
    OP_ACTIVATE = 3'd0,
    OP_PUSH     = 3'd1,
    OP_VALIDATE = 3'd2,
    OP_POP      = 3'd3,
    OP_CLASSIFY = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    FAULT_NONE      = 3'd0,
    FAULT_USAGE     = 3'd1,
    FAULT_CAPACITY  = 3'd2,
    FAULT_UNTRACKED = 3'd3,
    FAULT_NON_LIFO  = 3'd4,
    FAULT_BAD_POP   = 3'd5
  } fault_t;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_ACTIVE   = 2'd1,
    MODE_DEGRADED = 2'd2
  } mode_t;

  typedef enum logic [0:0] {
    REG_UNUSED_USAGE = 1'b0,
    REG_IRQ_MASK     = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

@@ hdl/hlc_if.sv @@
`timescale 1ns / 1ps
interface hlc_in_if import hlc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [ID_W-1:0]    lock_id;
  logic [3:0]         lock_kind;
  logic [3:0]         prior_level;
  logic [USAGE_W-1:0] old_usage;
  logic [USAGE_W-1:0] requested_usage;

  modport source (output valid, operation, lock_id, lock_kind, prior_level, old_usage,
                  requested_usage, input ready);
  modport sink (input valid, operation, lock_id, lock_kind, prior_level, old_usage,
                requested_usage, output ready);
endinterface

interface hlc_out_if import hlc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               pushed;
  logic [2:0]         fault_code;
  logic               usage_write;
  logic [USAGE_W-1:0] new_usage;
  logic [COUNT_W-1:0] held_count;

  modport source (output valid, pushed, fault_code, usage_write, new_usage, held_count,
                  input ready);
  modport sink (input valid, pushed, fault_code, usage_write, new_usage, held_count,
                output ready);
endinterface

@@ hdl/held_lock_lifo_checker_top.sv @@
`timescale 1ns / 1ps
// Held spin-lock LIFO checker. Keeps a stack of up to STACK_DEPTH held locks
// (identity, kind, prior interrupt level) in a row of cells, top entry in cell 0,
// plus a checker mode (inactive, active, degraded). Each input transaction is one
// operation: activate, push, validate top, pop or classify; each yields exactly one
// result transaction carrying pushed, fault_code, usage_write, new_usage and the
// stack depth after the operation. Rate: one transaction per clock cycle while the
// sink keeps up; the result is registered and shows in the cycle after acceptance. The
// rate is set by the compare against the top cell and the shift of the whole cell row
// on push or pop. A registered result that waits for the sink does not block the next
// input as long as the sink takes it in the same cycle. Outside the active mode every
// operation except activate is ignored and only reports the depth. The two usage
// registers sit at byte addresses 0 and 4 and reset to 0 and 255.
module held_lock_lifo_checker_top import hlc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  hlc_in_if.sink      in_ch,
  hlc_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  // Configuration registers
  logic [USAGE_W-1:0] unused_usage;
  logic [USAGE_W-1:0] irq_mask;

  hlc_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .unused_usage (unused_usage),
    .irq_mask     (irq_mask)
  );

  // Control state
  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] depth_r, depth_nxt;

  // Output register
  logic               out_valid_r;
  logic               pushed_r, pushed_nxt;
  fault_t             fault_r, fault_nxt;
  logic               uwrite_r, uwrite_nxt;
  logic [USAGE_W-1:0] unew_r, unew_nxt;

  logic       acc;
  logic       active;
  logic       full;
  logic       empty;
  entry_t     new_entry;
  entry_t     top;
  logic       id_match;
  shift_ctl_t shift;
  logic [EXT_W-1:0] depth_ext;

  entry_t chain [STACK_DEPTH];

  // Take a new transaction whenever the result slot is free or drains this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  assign active    = (mode_r == MODE_ACTIVE);
  assign full      = (depth_r == CNT_W'(STACK_DEPTH));
  assign empty     = (depth_r == '0);
  assign new_entry = '{id: in_ch.lock_id, tag: {in_ch.lock_kind, in_ch.prior_level}};
  assign top       = chain[0];
  assign id_match  = (top.id == in_ch.lock_id);

  // Operation decode: compute the result and the next mode and depth.
  always_comb begin
    mode_nxt   = mode_r;
    depth_nxt  = depth_r;
    pushed_nxt = 1'b0;
    fault_nxt  = FAULT_NONE;
    uwrite_nxt = 1'b0;
    unew_nxt   = '0;
    shift      = '{push: 1'b0, pop: 1'b0};
    if (acc) begin
      unique case (in_ch.operation)
        OP_ACTIVATE: begin
          mode_nxt = MODE_ACTIVE;
        end
        OP_PUSH: begin
          if (active) begin
            if (full) begin
              // Out of room: report capacity and stop checking until reactivated.
              fault_nxt = FAULT_CAPACITY;
              mode_nxt  = MODE_DEGRADED;
            end else begin
              shift.push = 1'b1;
              pushed_nxt = 1'b1;
              depth_nxt  = depth_r + CNT_W'(1);
            end
          end
        end
        OP_VALIDATE: begin
          if (active) begin
            if (empty) begin
              fault_nxt = FAULT_UNTRACKED;
            end else if (!id_match || top.tag != new_entry.tag) begin
              fault_nxt = FAULT_NON_LIFO;
            end
          end
        end
        OP_POP: begin
          // Pop only checks identity and kind; the prior level may differ.
          if (active) begin
            if (empty || !id_match || top.tag[7:4] != in_ch.lock_kind) begin
              fault_nxt = FAULT_BAD_POP;
            end else begin
              shift.pop = 1'b1;
              depth_nxt = depth_r - CNT_W'(1);
            end
          end
        end
        OP_CLASSIFY: begin
          if (active) begin
            if (in_ch.old_usage == unused_usage) begin
              // First use of the lock: store the requested flags.
              uwrite_nxt = 1'b1;
              unew_nxt   = in_ch.requested_usage;
            end else if (((in_ch.old_usage ^ in_ch.requested_usage) & irq_mask) != '0) begin
              fault_nxt = FAULT_USAGE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_INACTIVE;
      depth_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
    end
  end

  // Cell row: cell 0 is the top; push feeds the new entry into it, pop pulls from below.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t above;
    entry_t below;
    if (i == 0) begin : g_first
      assign above = new_entry;
    end else begin : g_inner_above
      assign above = chain[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = chain[i];
    end else begin : g_inner_below
      assign below = chain[i+1];
    end
    hlc_cell u_cell (
      .clk   (clk),
      .ctl   (shift),
      .above (above),
      .below (below),
      .q     (chain[i])
    );
  end

  // Result register: load on accept, hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pushed_r <= pushed_nxt;
      fault_r  <= fault_nxt;
      uwrite_r <= uwrite_nxt;
      unew_r   <= unew_nxt;
    end
  end

  // held_count reports the depth held in the register, which is already post-operation.
  logic [EXT_W-1:0] count_r;
  always_ff @(posedge clk) begin
    if (acc) begin
      count_r <= EXT_W'(depth_nxt);
    end
  end
  assign depth_ext = count_r;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pushed      = pushed_r;
  assign out_ch.fault_code  = fault_r;
  assign out_ch.usage_write = uwrite_r;
  assign out_ch.new_usage   = unew_r;
  assign out_ch.held_count  = depth_ext[COUNT_W-1:0];

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CNT_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && active && in_ch.operation == OP_PUSH && !full) |=>
      (depth_r == $past(depth_r) + CNT_W'(1)))
    else $error("accepted push did not grow the stack");

  a_uwrite_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.usage_write) |-> (out_ch.fault_code == FAULT_NONE))
    else $error("usage write reported together with a fault");
`endif

endmodule

@@ hdl/hlc_cell.sv @@
`timescale 1ns / 1ps
module hlc_cell import hlc_pkg::*; (
  input  logic       clk,
  input  shift_ctl_t ctl,
  input  entry_t     above,
  input  entry_t     below,
  output entry_t     q
);

  entry_t entry_r;
  entry_t entry_nxt;

  // Push shifts the stack down one cell, pop shifts it up.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.push) begin
      entry_nxt = above;
    end else if (ctl.pop) begin
      entry_nxt = below;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q = entry_r;

endmodule

@@ hdl/hlc_cfg.sv @@
`timescale 1ns / 1ps
module hlc_cfg import hlc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [USAGE_W-1:0] unused_usage,
  output logic [USAGE_W-1:0] irq_mask
);

  logic [USAGE_W-1:0] unused_usage_r;
  logic [USAGE_W-1:0] irq_mask_r;
  logic               wr_en;
  cfg_reg_t           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = cfg_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unused_usage_r <= '0;
      irq_mask_r     <= '1;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_UNUSED_USAGE: unused_usage_r <= pwdata[USAGE_W-1:0];
        REG_IRQ_MASK:     irq_mask_r     <= pwdata[USAGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_UNUSED_USAGE: prdata = {{(32-USAGE_W){1'b0}}, unused_usage_r};
      REG_IRQ_MASK:     prdata = {{(32-USAGE_W){1'b0}}, irq_mask_r};
      default:          prdata = '0;
    endcase
  end

  assign unused_usage = unused_usage_r;
  assign irq_mask     = irq_mask_r;

endmodule
